[hw/rtl/mppc_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the MPPC decompressor.
package mppc_pkg;

  localparam int WINDOW_SIZE = 8192;
  localparam int HIST_LIMIT  = 3 * WINDOW_SIZE;
  localparam int FILL_W      = 15;
  localparam int BUF_W       = 48;
  localparam int BC_W        = 6;
  localparam int CL_W        = 13;
  localparam int DIST_W      = 14;
  localparam int POS_W       = 6;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_BYTE = 2'd0;
  localparam kind_t KIND_EOP  = 2'd1;
  localparam kind_t KIND_PULL = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_OVF    = 2'd1;
  localparam status_t ST_BADLEN = 2'd2;
  localparam status_t ST_BUSY   = 2'd3;

  typedef enum logic [1:0] {
    RES_EMPTY,
    RES_BUSY,
    RES_DECODE,
    RES_COPY
  } res_sel_t;

  typedef struct packed {
    logic     take_byte;
    logic     eop;
    logic     align;
    logic     classify;
    logic     lens;
    logic     commit;
    logic     cmp_rd;
    logic     cmp_wr;
    logic     shrink;
    logic     burst_start;
    logic     cp_rd;
    logic     cp_wr;
    logic     emit;
    res_sel_t sel;
    logic     last;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic copy_pend;
    logic cmp_need;
    logic cmp_last;
    logic burst_last;
    logic out_free;
  } dp_stat_t;

endpackage

[hw/rtl/mppc_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module mppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/mppc_ctrl.sv]
// Controller state machine that sequences decoding, copy bursts and history compaction.
module mppc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  mppc_pkg::kind_t    in_kind,
  output logic               in_ready,
  input  mppc_pkg::dp_stat_t stat,
  output mppc_pkg::dp_cmd_t  cmd
);

  import mppc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALIGN,
    S_CLASS,
    S_LENS,
    S_DECIDE,
    S_EMPTY,
    S_BUSY,
    S_CMP_RD,
    S_CMP_WR,
    S_CMP_FIN,
    S_CP_RD,
    S_CP_WR
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_BYTE: begin
              if (stat.drop) begin
                state_next = S_EMPTY;
              end else if (stat.copy_pend) begin
                state_next = S_BUSY;
              end else begin
                cmd.take_byte = 1'b1;
                state_next    = S_ALIGN;
              end
            end
            KIND_EOP: begin
              cmd.eop    = 1'b1;
              state_next = stat.cmp_need ? S_CMP_RD : S_EMPTY;
            end
            KIND_PULL: begin
              if (stat.copy_pend) begin
                cmd.burst_start = 1'b1;
                state_next      = S_CP_RD;
              end else begin
                state_next = S_EMPTY;
              end
            end
            default: state_next = S_EMPTY;
          endcase
        end
      end
      S_ALIGN: begin
        cmd.align  = 1'b1;
        state_next = S_CLASS;
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_next   = S_LENS;
      end
      S_LENS: begin
        cmd.lens   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          cmd.emit   = 1'b1;
          cmd.sel    = RES_DECODE;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = RES_EMPTY;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BUSY: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = RES_BUSY;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CMP_RD: begin
        cmd.cmp_rd = 1'b1;
        state_next = S_CMP_WR;
      end
      S_CMP_WR: begin
        cmd.cmp_wr = 1'b1;
        state_next = stat.cmp_last ? S_CMP_FIN : S_CMP_RD;
      end
      S_CMP_FIN: begin
        cmd.shrink = 1'b1;
        state_next = S_EMPTY;
      end
      S_CP_RD: begin
        cmd.cp_rd  = 1'b1;
        state_next = S_CP_WR;
      end
      S_CP_WR: begin
        if (stat.out_free) begin
          cmd.cp_wr  = 1'b1;
          cmd.emit   = 1'b1;
          cmd.sel    = RES_COPY;
          cmd.last   = stat.burst_last;
          state_next = stat.burst_last ? S_IDLE : S_CP_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/mppc_dp.sv]
// Datapath: bit buffer, token decoder, history RAM, copy engine and result register.
module mppc_dp #(
  parameter int RING_DEPTH  = 32768,
  parameter int BURST_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  mppc_pkg::dp_cmd_t  cmd,
  output mppc_pkg::dp_stat_t stat,
  input  logic [7:0]         in_byte,
  input  logic               o_ready,
  output logic               o_valid,
  output logic [7:0]         o_byte,
  output logic               o_has,
  output logic               o_more,
  output logic               o_last,
  output mppc_pkg::status_t  o_st
);

  import mppc_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = (AW > FILL_W) ? AW : FILL_W;
  localparam int BW = $clog2(BURST_BYTES + 1);

  typedef enum logic [2:0] {
    DEC_NONE,
    DEC_LIT,
    DEC_SYNC,
    DEC_COPY,
    DEC_OVF,
    DEC_BADLEN
  } dec_t;

  // Architectural state.
  logic [BUF_W-1:0]  bbuf;
  logic [BC_W-1:0]   bc;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] hw;
  logic [CL_W-1:0]   copy_left;
  logic [DIST_W-1:0] cp_dist;
  logic              drop;

  // Working registers.
  logic [FILL_W-1:0] idx;
  logic [BW-1:0]     bcnt;
  logic              cp_more;
  logic              src_ok;
  logic [BUF_W-1:0]  win;
  dec_t              c_res;
  logic [7:0]        c_byte;
  logic [4:0]        c_obits;
  logic [DIST_W-1:0] c_off;
  logic [3:0]        c_k;
  logic [POS_W-1:0]  c_litn;
  dec_t              l_res;
  logic [CL_W-1:0]   l_len;
  logic [POS_W-1:0]  l_pos;

  // RAM wiring.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] src_addr;
  logic [7:0]    cp_data;

  mppc_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Entries never written read as zero.
  assign src_addr = AW'(fill) - AW'(cp_dist);
  assign cp_data  = src_ok ? ram_rdata : 8'd0;

  // Classification of the aligned window.
  logic [7:0]        v;
  logic [4:0]        obits;
  logic [11:0]       lead;
  logic [3:0]        kcnt;
  logic              kfound;
  logic [DIST_W-1:0] off;
  dec_t              cls;
  logic [POS_W-1:0]  litn;

  always_comb begin
    v    = win[BUF_W-1 -: 8];
    litn = v[7] ? POS_W'(9) : POS_W'(8);
    if (v[7:4] == 4'hF) begin
      obits = 5'd10;
      off   = DIST_W'(win[43:38]);
      lead  = win[37:26];
    end else if (v[7:4] == 4'hE) begin
      obits = 5'd12;
      off   = DIST_W'(win[43:36]) + DIST_W'(64);
      lead  = win[35:24];
    end else begin
      obits = 5'd16;
      off   = DIST_W'(win[44:32]) + DIST_W'(320);
      lead  = win[31:20];
    end
    // Length prefix: count of leading ones.
    kcnt   = 4'd12;
    kfound = 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (!kfound && !lead[11-i]) begin
        kcnt   = 4'(i);
        kfound = 1'b1;
      end
    end
    if (bc < BC_W'(8)) begin
      cls = DEC_NONE;
    end else if (!v[7]) begin
      cls = DEC_LIT;
    end else if (v[7:6] == 2'b10) begin
      cls = (bc >= BC_W'(9)) ? DEC_LIT : DEC_NONE;
    end else if (bc < BC_W'(obits)) begin
      cls = DEC_NONE;
    end else if (obits == 5'd10 && win[43:38] == 6'd0) begin
      cls = DEC_SYNC;
    end else if (kcnt == 4'd12) begin
      cls = DEC_BADLEN;
    end else if (BC_W'(obits) + BC_W'(kcnt) >= bc) begin
      cls = DEC_NONE;
    end else begin
      cls = DEC_COPY;
    end
  end

  // Length field extraction and overflow checks.
  logic [POS_W-1:0]  lsh;
  logic [BUF_W-1:0]  lwin;
  logic [11:0]       lbits;
  logic [CL_W-1:0]   len;
  logic [POS_W-1:0]  pos;
  logic [FILL_W:0]   fill_len;
  dec_t              lres;

  always_comb begin
    lsh   = POS_W'(c_obits) + POS_W'(c_k) + POS_W'(1);
    lwin  = win << lsh;
    lbits = lwin[BUF_W-1 -: 12] >> (4'd11 - c_k);
    if (c_k == 4'd0) begin
      len = CL_W'(3);
      pos = POS_W'(c_obits) + POS_W'(1);
    end else begin
      len = (CL_W'(1) << (c_k + 4'd1)) | CL_W'(lbits);
      pos = POS_W'(c_obits) + POS_W'({c_k, 1'b0}) + POS_W'(2);
    end
    fill_len = {1'b0, fill} + (FILL_W + 1)'(len);
    case (c_res)
      DEC_LIT: begin
        lres = (fill >= FILL_W'(HIST_LIMIT)) ? DEC_OVF : DEC_LIT;
        pos  = c_litn;
      end
      DEC_COPY: begin
        if (c_k != 4'd0 && POS_W'(bc) < pos) begin
          lres = DEC_NONE;
        end else if (fill_len >= (FILL_W + 1)'(HIST_LIMIT)) begin
          lres = DEC_OVF;
        end else begin
          lres = DEC_COPY;
        end
      end
      default: lres = c_res;
    endcase
  end

  // RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(fill);
    ram_wdata = c_byte;
    ram_re    = cmd.cmp_rd || cmd.cp_rd;
    ram_raddr = cmd.cmp_rd ? AW'(idx + FILL_W'(WINDOW_SIZE)) : src_addr;
    if (cmd.commit && l_res == DEC_LIT) begin
      ram_we = 1'b1;
    end else if (cmd.cmp_wr) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(idx);
      ram_wdata = ram_rdata;
    end else if (cmd.cp_wr) begin
      ram_we    = 1'b1;
      ram_wdata = cp_data;
    end
  end

  // Decoder pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      bbuf <= {bbuf[BUF_W-9:0], in_byte};
    end
    if (cmd.align) begin
      win <= bbuf << (BC_W'(BUF_W) - bc);
    end
    if (cmd.classify) begin
      c_res   <= cls;
      c_byte  <= v[7] ? {1'b1, win[45:39]} : v;
      c_obits <= obits;
      c_off   <= off;
      c_k     <= kcnt;
      c_litn  <= litn;
    end
    if (cmd.lens) begin
      l_res <= lres;
      l_len <= len;
      l_pos <= pos;
    end
    if (cmd.cp_rd) begin
      src_ok <= CW'(src_addr) < CW'(hw);
    end
    if (cmd.burst_start) begin
      cp_more <= copy_left > CL_W'(BURST_BYTES);
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      bc        <= '0;
      fill      <= '0;
      hw        <= '0;
      copy_left <= '0;
      cp_dist   <= '0;
      drop      <= 1'b0;
      idx       <= '0;
      bcnt      <= '0;
    end else begin
      if (cmd.take_byte) begin
        bc <= bc + BC_W'(8);
      end
      if (cmd.eop) begin
        bc   <= '0;
        drop <= 1'b0;
        idx  <= '0;
      end
      if (cmd.commit) begin
        case (l_res)
          DEC_LIT: begin
            bc   <= bc - BC_W'(l_pos);
            fill <= fill + FILL_W'(1);
            if (fill + FILL_W'(1) > hw) begin
              hw <= fill + FILL_W'(1);
            end
          end
          DEC_SYNC: begin
            bc <= (bc - BC_W'(10)) & ~BC_W'(7);
          end
          DEC_COPY: begin
            bc        <= bc - BC_W'(l_pos);
            copy_left <= l_len;
            cp_dist   <= c_off;
          end
          DEC_OVF, DEC_BADLEN: begin
            bc   <= '0;
            drop <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.cmp_wr) begin
        idx <= idx + FILL_W'(1);
      end
      if (cmd.shrink) begin
        fill <= fill - FILL_W'(WINDOW_SIZE);
      end
      if (cmd.burst_start) begin
        bcnt <= (copy_left < CL_W'(BURST_BYTES)) ? BW'(copy_left) : BW'(BURST_BYTES);
      end
      if (cmd.cp_wr) begin
        fill      <= fill + FILL_W'(1);
        copy_left <= copy_left - CL_W'(1);
        bcnt      <= bcnt - BW'(1);
        if (fill + FILL_W'(1) > hw) begin
          hw <= fill + FILL_W'(1);
        end
      end
    end
  end

  // Status towards the controller.
  assign stat.drop       = drop;
  assign stat.copy_pend  = (copy_left != '0);
  assign stat.cmp_need   = (fill > FILL_W'(2 * WINDOW_SIZE));
  assign stat.cmp_last   = (idx == fill - FILL_W'(WINDOW_SIZE + 1));
  assign stat.burst_last = (bcnt == BW'(1));
  assign stat.out_free   = !o_valid || o_ready;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.emit) begin
      o_valid <= 1'b1;
    end else if (o_ready) begin
      o_valid <= 1'b0;
    end
  end

  // Fields of the next result.
  logic [7:0] res_byte;
  logic       res_has;
  logic       res_more;
  status_t    res_st;

  always_comb begin
    res_byte = 8'd0;
    res_has  = 1'b0;
    res_more = (copy_left != '0);
    res_st   = ST_OK;
    case (cmd.sel)
      RES_BUSY: res_st = ST_BUSY;
      RES_DECODE: begin
        case (l_res)
          DEC_LIT: begin
            res_byte = c_byte;
            res_has  = 1'b1;
          end
          DEC_COPY:   res_more = 1'b1;
          DEC_OVF:    res_st   = ST_OVF;
          DEC_BADLEN: res_st   = ST_BADLEN;
          default: ;
        endcase
      end
      RES_COPY: begin
        res_byte = cp_data;
        res_has  = 1'b1;
        res_more = cp_more;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_last <= cmd.last;
      o_byte <= res_byte;
      o_has  <= res_has;
      o_more <= res_more;
      o_st   <= res_st;
    end
  end

endmodule

[hw/rtl/mppc_decompressor_top.sv]
// MPPC decompressor top level: stream ports, controller and datapath.
// Requests carry a compressed byte, an end of packet or a pull of pending copy bytes, and
// the block takes one request at a time. A compressed byte is handled in the steps accept and
// shift in, align, classify, length extraction and commit, plus any wait on the result port. A pull
// gives up to BURST_BYTES results, each with one read and one write of the single history
// RAM per byte and any wait on the result port. An end of packet with more than two windows
// of history moves the history down by one window, one read and one write per byte. No
// clearing pass is needed after reset: a high-water mark makes unwritten entries read as zero.
module mppc_decompressor_top #(
  parameter int RING_DEPTH  = 32768,
  parameter int BURST_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] more_pending, [10:9] status
  output logic        m_tuser,   // [0] has_byte
  output logic        m_tlast
);

  import mppc_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [7:0] o_byte;
  logic       o_more;
  status_t    o_st;

  mppc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_kind (s_tuser),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  mppc_dp #(
    .RING_DEPTH (RING_DEPTH),
    .BURST_BYTES(BURST_BYTES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .in_byte(s_tdata),
    .o_ready(m_tready),
    .o_valid(m_tvalid),
    .o_byte (o_byte),
    .o_has  (m_tuser),
    .o_more (o_more),
    .o_last (m_tlast),
    .o_st   (o_st)
  );

  assign m_tdata = {5'd0, o_st, o_more, o_byte};

`ifndef ASSERT_OFF
  // A byte refused for a pending copy always reports the copy as pending.
  a_busy_pending: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[10:9] == ST_BUSY) |-> m_tdata[8])
    else $error("refused byte without pending copy");

  // A decompressed byte never comes with an error status.
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[10:9] == ST_OK))
    else $error("byte carried with error status");

  // A result without a byte carries a zero byte.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'd0))
    else $error("empty result with non-zero byte");
`endif

endmodule
